[hdl/piec_pkg.sv]
// Shared types and constants of the prescaled IRQ event counter.
`default_nettype none

package piec_pkg;

    // Bus event kinds; the control byte's clock-source field uses the same codes
    typedef enum logic [1:0] {
        ACT_CPU_TICK  = 2'd0,
        ACT_A12_SEEN  = 2'd1,
        ACT_PPU_READ  = 2'd2,
        ACT_CPU_WRITE = 2'd3
    } t_action;

    // Count direction codes (control bits 7..6)
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    // IRQ register numbers
    localparam logic [2:0] REG_ENABLE    = 3'd0;
    localparam logic [2:0] REG_CONTROL   = 3'd1;
    localparam logic [2:0] REG_DISABLE   = 3'd2;
    localparam logic [2:0] REG_SET_EN    = 3'd3;
    localparam logic [2:0] REG_PRESCALER = 3'd4;
    localparam logic [2:0] REG_COUNTER   = 3'd5;
    localparam logic [2:0] REG_XOR_KEY   = 3'd6;

    // Control byte fields
    localparam int CTL_MASK_BIT   = 2;
    localparam int CTL_FREEZE_BIT = 3;

    // Prescaler masks and counter wrap values
    localparam logic [7:0] MASK_NARROW = 8'h07;
    localparam logic [7:0] MASK_WIDE   = 8'hFF;
    localparam logic [7:0] WRAP_UP     = 8'h00;
    localparam logic [7:0] WRAP_DOWN   = 8'hFF;

    // One input request
    typedef struct packed {
        t_action    action;
        logic       ppu_a12;
        logic       irq_reg_hit;
        logic [2:0] reg_index;
        logic [7:0] write_value;
    } t_item;

    // One result
    typedef struct packed {
        logic       irq_asserted;
        logic [7:0] counter_value;
        logic [7:0] prescaler_value;
    } t_result;

endpackage

`default_nettype wire

[hdl/piec_in_stage.sv]
// Input register stage of the IRQ event counter.
`default_nettype none

module piec_in_stage (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire piec_pkg::t_item i_item,
    input  wire logic            i_advance,
    output logic                 o_valid,
    output piec_pkg::t_item      o_item
);

    logic            r_valid;
    logic            n_valid;
    piec_pkg::t_item r_item;

    // Take a new request whenever the stage is empty or moving on
    assign o_ready = !r_valid || i_advance;
    assign n_valid = (i_valid && o_ready) || (r_valid && !i_advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Hold the payload until the next request is taken
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

[hdl/piec_core.sv]
// Counter state and single-pass next-state logic of the IRQ event counter.
`default_nettype none

module piec_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_fire,
    input  wire piec_pkg::t_item i_item,
    output piec_pkg::t_result    o_result
);

    logic       r_enabled,  n_enabled;
    logic [7:0] r_control,  n_control;
    logic [7:0] r_prescaler, n_prescaler;
    logic [7:0] r_counter,  n_counter;
    logic [7:0] r_xor_key,  n_xor_key;
    logic       r_prev_a12, n_prev_a12;
    logic       r_irq,      n_irq;

    logic       src_hit;
    logic       do_clock;
    logic [7:0] mask;
    logic       frozen;
    logic [1:0] dir;
    logic [7:0] pre_sum;
    logic [7:0] clk_pre;
    logic [7:0] clk_cnt;
    logic       clk_irq;
    logic       is_write;

    assign mask     = r_control[piec_pkg::CTL_MASK_BIT] ? piec_pkg::MASK_NARROW
                                                        : piec_pkg::MASK_WIDE;
    assign frozen   = r_control[piec_pkg::CTL_FREEZE_BIT];
    assign dir      = r_control[7:6];
    assign is_write = (i_item.action == piec_pkg::ACT_CPU_WRITE);

    // Decide whether this request clocks the prescaler
    always_comb begin
        src_hit = (r_control[1:0] == i_item.action);
        case (i_item.action)
            piec_pkg::ACT_A12_SEEN: do_clock = src_hit && i_item.ppu_a12 && !r_prev_a12;
            default:                do_clock = src_hit;
        endcase
    end

    // Step the prescaler's masked low part and the main counter
    always_comb begin
        clk_pre = r_prescaler;
        clk_cnt = r_counter;
        clk_irq = r_irq;
        pre_sum = r_prescaler;
        if (do_clock && r_enabled) begin
            if (dir == piec_pkg::DIR_UP) begin
                pre_sum = r_prescaler + 8'd1;
                clk_pre = (r_prescaler & ~mask) | (pre_sum & mask);
                if ((pre_sum & mask) == 8'h00) begin
                    if (!frozen) begin
                        clk_cnt = r_counter + 8'd1;
                    end
                    if (clk_cnt == piec_pkg::WRAP_UP) begin
                        clk_irq = 1'b1;
                    end
                end
            end else if (dir == piec_pkg::DIR_DOWN) begin
                pre_sum = r_prescaler - 8'd1;
                clk_pre = (r_prescaler & ~mask) | (pre_sum & mask);
                if ((pre_sum & mask) == mask) begin
                    if (!frozen) begin
                        clk_cnt = r_counter - 8'd1;
                    end
                    if (clk_cnt == piec_pkg::WRAP_DOWN) begin
                        clk_irq = 1'b1;
                    end
                end
            end
        end
    end

    // Apply the register write after the clock
    always_comb begin
        n_enabled   = r_enabled;
        n_control   = r_control;
        n_prescaler = clk_pre;
        n_counter   = clk_cnt;
        n_xor_key   = r_xor_key;
        n_irq       = clk_irq;
        n_prev_a12  = (i_item.action == piec_pkg::ACT_A12_SEEN) ? i_item.ppu_a12
                                                                  : r_prev_a12;
        if (is_write && i_item.irq_reg_hit) begin
            unique case (i_item.reg_index)
                piec_pkg::REG_ENABLE: begin
                    n_enabled = i_item.write_value[0];
                    if (!i_item.write_value[0]) begin
                        n_prescaler = 8'h00;
                        n_irq       = 1'b0;
                    end
                end
                piec_pkg::REG_CONTROL: begin
                    n_control = i_item.write_value;
                end
                piec_pkg::REG_DISABLE: begin
                    n_enabled   = 1'b0;
                    n_prescaler = 8'h00;
                    n_irq       = 1'b0;
                end
                piec_pkg::REG_SET_EN: begin
                    n_enabled = 1'b1;
                end
                piec_pkg::REG_PRESCALER: begin
                    n_prescaler = i_item.write_value ^ r_xor_key;
                end
                piec_pkg::REG_COUNTER: begin
                    n_counter = i_item.write_value ^ r_xor_key;
                end
                piec_pkg::REG_XOR_KEY: begin
                    n_xor_key = i_item.write_value;
                end
                default: begin
                end
            endcase
        end
    end

    // Advance the state once per request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled   <= 1'b0;
            r_control   <= 8'h00;
            r_prescaler <= 8'h00;
            r_counter   <= 8'h00;
            r_xor_key   <= 8'h00;
            r_prev_a12  <= 1'b0;
            r_irq       <= 1'b0;
        end else if (i_fire) begin
            r_enabled   <= n_enabled;
            r_control   <= n_control;
            r_prescaler <= n_prescaler;
            r_counter   <= n_counter;
            r_xor_key   <= n_xor_key;
            r_prev_a12  <= n_prev_a12;
            r_irq       <= n_irq;
        end
    end

    assign o_result.irq_asserted    = n_irq;
    assign o_result.counter_value   = n_counter;
    assign o_result.prescaler_value = n_prescaler;

    // State only moves when a request is processed
    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_irq) && $stable(r_counter) && $stable(r_prescaler))
        else $error("counter state moved without a request");

    // A disable write clears the prescaler and releases the line
    a_disable_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && is_write && i_item.irq_reg_hit
            && i_item.reg_index == piec_pkg::REG_DISABLE
        |=> !r_enabled && r_prescaler == 8'h00 && !r_irq)
        else $error("disable write did not clear state");

    // While disabled and not written, the counters stay put
    a_disabled_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && !r_enabled && !(is_write && i_item.irq_reg_hit)
        |=> $stable(r_prescaler) && $stable(r_counter) && r_irq == $past(r_irq))
        else $error("disabled counter moved");

endmodule

`default_nettype wire

[hdl/piec_out_stage.sv]
// Result register stage of the IRQ event counter.
`default_nettype none

module piec_out_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire piec_pkg::t_result i_result,
    input  wire logic              i_ready,
    output logic                   o_valid,
    output piec_pkg::t_result      o_result
);

    logic              r_valid;
    piec_pkg::t_result r_result;

    // Hold a result until it is taken; a load replaces it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

[hdl/prescaled_irq_event_counter.sv]
// Top level of the prescaled IRQ event counter.
// Takes bus event requests and returns one result per event
// (IRQ line, main counter, prescaler after that event). A request is caught
// in an input register; the single-pass update logic then advances the
// counter state and loads the result register. The sustained rate is one
// request per clock whenever the result side takes its results.
// Back-pressure from the result side stalls the input register, which then
// holds one request.
`default_nettype none

module prescaled_irq_event_counter (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [1:0] i_action,
    input  wire logic       i_ppu_a12,
    input  wire logic       i_irq_reg_hit,
    input  wire logic [2:0] i_reg_index,
    input  wire logic [7:0] i_write_value,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic            o_irq_asserted,
    output logic [7:0]      o_counter_value,
    output logic [7:0]      o_prescaler_value
);

    piec_pkg::t_item   in_item;
    piec_pkg::t_item   s1_item;
    logic              s1_valid;
    logic              advance;
    piec_pkg::t_result core_result;
    piec_pkg::t_result out_result;

    // Pack the request fields
    assign in_item.action      = piec_pkg::t_action'(i_action);
    assign in_item.ppu_a12     = i_ppu_a12;
    assign in_item.irq_reg_hit = i_irq_reg_hit;
    assign in_item.reg_index   = i_reg_index;
    assign in_item.write_value = i_write_value;

    // Move a request on when the result register is free or being emptied
    assign advance = s1_valid && (!o_valid || i_ready);

    piec_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (s1_valid),
        .o_item    (s1_item)
    );

    piec_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (s1_item),
        .o_result (core_result)
    );

    piec_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (core_result),
        .i_ready  (i_ready),
        .o_valid  (o_valid),
        .o_result (out_result)
    );

    assign o_irq_asserted    = out_result.irq_asserted;
    assign o_counter_value   = out_result.counter_value;
    assign o_prescaler_value = out_result.prescaler_value;

endmodule

`default_nettype wire
